// File: hw/rtl/bd3_pkg.sv
package bd3_pkg;

   localparam int CH_W      = 8;
   localparam int TRI_W     = 10;
   localparam int SUM_W     = 12;
   localparam int COL_W     = 12;
   localparam int ROW_W     = 13;
   localparam int OC_W      = 11;
   localparam int OROW_W    = 12;
   localparam int WIDTH_W   = 13;
   localparam int OCOLS_W   = 11;
   localparam int OROWS_W   = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 13;

   localparam logic [ROW_W-1:0]   ROW_SAT   = 13'd8191;
   localparam logic [WIDTH_W-1:0] COL_LIMIT = 13'd4096;

   localparam logic [WIDTH_W-1:0] IN_WIDTH_RST = 13'd1920;
   localparam logic [OCOLS_W-1:0] OUT_COLS_RST = 11'd640;
   localparam logic [OROWS_W-1:0] OUT_ROWS_RST = 12'd360;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_ROWS = 2'd2;

   // floor(x * 455 / 4096) is floor(x / 9) or one less for x below 4096
   localparam logic [20:0] DIV9_RECIP = 21'd455;
   localparam logic [12:0] DIV9_DIV   = 13'd9;

   typedef struct packed {
      logic [TRI_W-1:0] red;
      logic [TRI_W-1:0] green;
      logic [TRI_W-1:0] blue;
   } tri_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } col_type;

   typedef struct packed {
      logic            valid;
      logic [OC_W-1:0] oc;
      logic            first_row;
      logic            emit;
      logic            last;
      tri_type         triple;
   } acc_req_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
      logic            frame_last;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } acc_out_type;

   function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
      logic [20:0] prod;
      logic [8:0]  q;
      logic [12:0] rem;
      prod = {9'd0, x} * DIV9_RECIP;
      q    = prod[20:12];
      rem  = {1'b0, x} - ({4'd0, q} * DIV9_DIV);
      if (rem >= DIV9_DIV) begin
         q = q + 9'd1;
      end
      return q[CH_W-1:0];
   endfunction

endpackage

// File: hw/rtl/bd3_req_if.sv
interface bd3_req_if import bd3_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            frame_start;
   logic [CH_W-1:0] in_blue;
   logic [CH_W-1:0] in_green;
   logic [CH_W-1:0] in_red;

   modport source (output valid, frame_start, in_blue, in_green, in_red, input ready);
   modport sink   (input valid, frame_start, in_blue, in_green, in_red, output ready);
endinterface

// File: hw/rtl/bd3_rsp_if.sv
interface bd3_rsp_if import bd3_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_blue;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_red;
   logic            frame_last;

   modport source (output valid, out_blue, out_green, out_red, frame_last, input ready);
   modport sink   (input valid, out_blue, out_green, out_red, frame_last, output ready);
endinterface

// File: hw/rtl/bd3_acc.sv
module bd3_acc import bd3_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  acc_req_type acc_req,
   output acc_out_type acc_out
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   col_type             mem [DEPTH];
   col_type             rd_data_ff;
   logic                s1_valid_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_first_ff;
   logic                s1_emit_ff;
   logic                s1_last_ff;
   tri_type             s1_triple_ff;
   logic [ADDR_W-1:0]   req_addr;
   col_type             base;
   col_type             sum;

   assign req_addr = ADDR_W'(acc_req.oc);

   always_ff @(posedge clock) begin
      if (acc_req.valid) begin
         rd_data_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem[s1_addr_ff] <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= acc_req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_req.valid) begin
         s1_addr_ff   <= req_addr;
         s1_first_ff  <= acc_req.first_row;
         s1_emit_ff   <= acc_req.emit;
         s1_last_ff   <= acc_req.last;
         s1_triple_ff <= acc_req.triple;
      end
   end

   // the first line of a block row starts a fresh column sum
   always_comb begin
      base      = s1_first_ff ? '0 : rd_data_ff;
      sum.blue  = base.blue  + SUM_W'(s1_triple_ff.blue);
      sum.green = base.green + SUM_W'(s1_triple_ff.green);
      sum.red   = base.red   + SUM_W'(s1_triple_ff.red);
   end

   assign acc_out.valid           = s1_valid_ff && s1_emit_ff;
   assign acc_out.item.blue       = div9(sum.blue);
   assign acc_out.item.green      = div9(sum.green);
   assign acc_out.item.red        = div9(sum.red);
   assign acc_out.item.frame_last = s1_last_ff;

   // column events are at least three transfers apart, so no read meets a pending write
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(acc_req.valid && s1_valid_ff))
      else $error("column read overlaps pending write");

   a_first_not_emit: assert property (@(posedge clock) disable iff (reset)
      acc_req.valid |-> !(acc_req.first_row && acc_req.emit))
      else $error("block row cannot start and finish on one line");

   a_emit_follows: assert property (@(posedge clock) disable iff (reset)
      acc_req.valid && acc_req.emit |=> acc_out.valid)
      else $error("finishing column event lost");

endmodule

// File: hw/rtl/box_downscale_3x3_rgb.sv
// 3x3 box downscaler for a raster-order RGB pixel stream.
// req_chan takes one pixel per transfer; frame_start marks the first pixel of
// a frame and clears the position counters. rsp_chan gives one pixel per 3x3
// block, each channel the block sum divided by 9 (truncated); frame_last flags
// the bottom-right block of the frame. Only the top-left out_rows x out_cols
// blocks are produced, all other pixels are dropped.
// csr_we/csr_index/csr_data write in_width (0), out_cols (1), out_rows (2);
// write them only while the block is idle.
// Throughput: one pixel per clock, sustained while rsp_chan keeps up. The limit
// is the single-port line store of column sums: each block column reads at its
// third pixel and writes back in the following cycle.
// A result is registered in the line store read stage at the transfer of the
// pixel that completes its block, then summed, divided and written into the
// result buffer that drives rsp_chan.
// Results queue in a two-entry buffer; while rsp_chan stalls, req_chan.ready
// drops once the buffer plus the result in flight would fill it.
// Reset clears counters, the partial triple sum and the result buffer and
// restores the register defaults; req_chan.ready stays low while reset is
// high. The line store needs no clearing pass.
module box_downscale_3x3_rgb import bd3_pkg::*; #(
   parameter int MAX_OUT_COLS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   bd3_req_if.sink              req_chan,
   bd3_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   logic [WIDTH_W-1:0] in_width_ff;
   logic [OCOLS_W-1:0] out_cols_ff;
   logic [OROWS_W-1:0] out_rows_ff;

   logic [COL_W-1:0]   col_ff,  col_in;
   logic [1:0]         jc_ff,   jc_in;
   logic [OC_W-1:0]    oc_ff,   oc_in;
   logic [ROW_W-1:0]   row_ff,  row_in;
   logic [1:0]         ir_ff,   ir_in;
   logic [OROW_W-1:0]  orow_ff, orow_in;
   tri_type            triple_ff, triple_in;

   logic [COL_W-1:0]   col_c;
   logic [1:0]         jc_c;
   logic [OC_W-1:0]    oc_c;
   logic [ROW_W-1:0]   row_c;
   logic [1:0]         ir_c;
   logic [OROW_W-1:0]  orow_c;
   logic [WIDTH_W-1:0] width_eff;
   logic [OCOLS_W-1:0] cols_eff;
   logic               in_region;
   logic               req_fire;
   acc_req_type        acc_req;
   acc_out_type        acc_out;

   rsp_item_type       buf_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         cnt_ff;
   logic               push, pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff <= IN_WIDTH_RST;
         out_cols_ff <= OUT_COLS_RST;
         out_rows_ff <= OUT_ROWS_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_IN_WIDTH: in_width_ff <= csr_data;
            REG_OUT_COLS: out_cols_ff <= csr_data[OCOLS_W-1:0];
            REG_OUT_ROWS: out_rows_ff <= csr_data[OROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (in_width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (in_width_ff > COL_LIMIT) begin
         width_eff = COL_LIMIT;
      end else begin
         width_eff = in_width_ff;
      end
      if ({2'd0, out_cols_ff} > 13'(MAX_OUT_COLS)) begin
         cols_eff = OCOLS_W'(MAX_OUT_COLS);
      end else begin
         cols_eff = out_cols_ff;
      end
   end

   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      // a frame start clears the position before the pixel counts
      col_c  = req_chan.frame_start ? '0 : col_ff;
      jc_c   = req_chan.frame_start ? '0 : jc_ff;
      oc_c   = req_chan.frame_start ? '0 : oc_ff;
      row_c  = req_chan.frame_start ? '0 : row_ff;
      ir_c   = req_chan.frame_start ? '0 : ir_ff;
      orow_c = req_chan.frame_start ? '0 : orow_ff;

      in_region = (row_c < ROW_SAT) && ({1'b0, oc_c} < {1'b0, cols_eff})
                  && (orow_c < out_rows_ff);

      triple_in = triple_ff;
      if (in_region) begin
         if (jc_c == 2'd0) begin
            triple_in.blue  = TRI_W'(req_chan.in_blue);
            triple_in.green = TRI_W'(req_chan.in_green);
            triple_in.red   = TRI_W'(req_chan.in_red);
         end else begin
            triple_in.blue  = triple_ff.blue  + TRI_W'(req_chan.in_blue);
            triple_in.green = triple_ff.green + TRI_W'(req_chan.in_green);
            triple_in.red   = triple_ff.red   + TRI_W'(req_chan.in_red);
         end
      end

      acc_req.valid     = req_fire && in_region && (jc_c == 2'd2);
      acc_req.oc        = oc_c;
      acc_req.first_row = (ir_c == 2'd0);
      acc_req.emit      = (ir_c == 2'd2);
      acc_req.last      = ({1'b0, oc_c} + 12'd1 == {1'b0, cols_eff})
                          && ({1'b0, orow_c} + 13'd1 == {1'b0, out_rows_ff});
      acc_req.triple    = triple_in;

      col_in  = col_c + 12'd1;
      jc_in   = (jc_c == 2'd2) ? 2'd0 : jc_c + 2'd1;
      oc_in   = (jc_c == 2'd2) ? oc_c + 11'd1 : oc_c;
      row_in  = row_c;
      ir_in   = ir_c;
      orow_in = orow_c;
      if ({1'b0, col_c} + 13'd1 >= width_eff) begin
         col_in = '0;
         jc_in  = '0;
         oc_in  = '0;
         // hold the row at saturation
         if (row_c < ROW_SAT) begin
            row_in  = row_c + 13'd1;
            ir_in   = (ir_c == 2'd2) ? 2'd0 : ir_c + 2'd1;
            orow_in = (ir_c == 2'd2) ? orow_c + 12'd1 : orow_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         jc_ff     <= '0;
         oc_ff     <= '0;
         row_ff    <= '0;
         ir_ff     <= '0;
         orow_ff   <= '0;
         triple_ff <= '0;
      end else if (req_fire) begin
         col_ff    <= col_in;
         jc_ff     <= jc_in;
         oc_ff     <= oc_in;
         row_ff    <= row_in;
         ir_ff     <= ir_in;
         orow_ff   <= orow_in;
         triple_ff <= triple_in;
      end
   end

   bd3_acc #(.DEPTH(MAX_OUT_COLS)) u_acc (
      .clock   (clock),
      .reset   (reset),
      .acc_req (acc_req),
      .acc_out (acc_out)
   );

   // result buffer: two entries
   assign push = acc_out.valid;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= acc_out.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // leave room for the result in flight plus one more
   assign req_chan.ready = !reset && (({1'b0, cnt_ff} + {2'd0, push}) <= 3'd1);

   assign rsp_chan.valid      = (cnt_ff != '0);
   assign rsp_chan.out_blue   = buf_ff[rd_ptr_ff].blue;
   assign rsp_chan.out_green  = buf_ff[rd_ptr_ff].green;
   assign rsp_chan.out_red    = buf_ff[rd_ptr_ff].red;
   assign rsp_chan.frame_last = buf_ff[rd_ptr_ff].frame_last;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && cnt_ff == 2'd2))
      else $error("result buffer overflow");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.frame_start |=> col_ff <= 12'd1 && row_ff <= 13'd1)
      else $error("frame start did not clear position");

endmodule
